// ===== sv/bdf1_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bdf1_pkg
// Shared types and constants for the direct form I biquad section.
// ----------------------------------------------------------------------------
package bdf1_pkg;

  localparam int COEF_W     = 26;
  localparam int SAMPLE_W   = 24;
  localparam int PROD_W     = COEF_W + SAMPLE_W;
  localparam int ACC_W      = PROD_W + 3;
  localparam int REG_IDX_W  = 3;
  localparam int SAMPLE_MAX = 8388607;
  localparam int SAMPLE_MIN = -8388608;

  localparam int CHANNELS_DEF       = 2;
  localparam int COEF_FRAC_BITS_DEF = 22;

  localparam logic signed [COEF_W-1:0] B0_RESET = 26'sd4194304;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_B0 = 3'd0,
    REG_B1 = 3'd1,
    REG_B2 = 3'd2,
    REG_A1 = 3'd3,
    REG_A2 = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] b0;
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] b2;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
  } coef_set_t;

  // Per-channel history word as held in the state memory
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] x1;
    logic signed [SAMPLE_W-1:0] x2;
    logic signed [SAMPLE_W-1:0] y1;
    logic signed [SAMPLE_W-1:0] y2;
  } hist_t;

  // Control tag that travels with each request down the pipeline
  typedef struct packed {
    logic valid;
    logic channel;
    logic in_range;
  } tag_t;

endpackage
`default_nettype wire

// ===== sv/biquad_direct_form_one_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// biquad_direct_form_one_core
// Direct form I biquad section for interleaved audio channels.
// ----------------------------------------------------------------------------
// Each request carries a channel number and a signed 24-bit sample; the core
// returns one result per request, in order, holding
// round(b0*x + b1*x1 + b2*x2 - a1*y1 - a2*y2) saturated to 24 bits with a
// clip flag. Rounding is half toward plus infinity at COEF_FRAC_BITS.
// Per-channel history (two past inputs, two past outputs) lives in one small
// RAM with a registered read; a valid bit per channel, cleared by reset,
// makes unwritten history read as zero, so no clearing pass is needed.
// The pipeline is read, multiply, accumulate, then round/saturate with
// write-back into the output register. Requests on different channels enter
// one per cycle. A request whose channel is still in flight is held until
// the earlier one has written back. The channel number is one bit wide, so
// at most two channels interleave and the core cannot sustain one request
// per cycle. The whole pipeline holds while a result waits under out_stall.
// Write coefficients only while the core is idle.
// ----------------------------------------------------------------------------
module biquad_direct_form_one_core
  import bdf1_pkg::*;
#(
  parameter int CHANNELS       = CHANNELS_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  // configuration
  input  wire logic                       cfg_write,
  input  wire logic [REG_IDX_W-1:0]       cfg_index,
  input  wire logic [COEF_W-1:0]          cfg_data,
  // request channel
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic                       channel,
  input  wire logic signed [SAMPLE_W-1:0] sample_in,
  // result channel
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic                            channel_out,
  output logic signed [SAMPLE_W-1:0]      sample_out,
  output logic                            clipped
);

  localparam int CH_AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(SAMPLE_MAX);
  localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(SAMPLE_MIN);

  coef_set_t coefs;

  // Pipeline control
  logic advance;
  logic hazard;
  logic accept;
  logic in_range_now;

  // Read stage
  tag_t                       tag_rd;
  logic signed [SAMPLE_W-1:0] x_rd;
  hist_t                      hist_raw;
  hist_t                      hist_rd;
  logic [CHANNELS-1:0]        hist_valid;

  // MAC outputs
  tag_t                       tag_prod;
  tag_t                       tag_acc;
  logic signed [ACC_W-1:0]    acc;
  hist_t                      hist_acc;

  // Round and saturate
  logic signed [ACC_W-1:0]    shifted;
  logic signed [SAMPLE_W-1:0] y_sat;
  logic                       clip;
  logic                       wb_en;
  hist_t                      hist_wb;

  bdf1_coef_regs u_coef_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coefs     (coefs)
  );

  // Advance the whole pipeline unless a result is waiting to be taken.
  assign advance      = !out_valid || !out_stall;
  assign in_range_now = int'(channel) < CHANNELS;

  // Hold a request whose channel history is still being updated downstream.
  assign hazard = in_range_now && (
      (tag_rd.valid   && tag_rd.in_range   && (tag_rd.channel   == channel)) ||
      (tag_prod.valid && tag_prod.in_range && (tag_prod.channel == channel)) ||
      (tag_acc.valid  && tag_acc.in_range  && (tag_acc.channel  == channel)));

  assign in_stall = !advance || hazard;
  assign accept   = in_valid && !in_stall;

  // History memory: read on acceptance, written back as a result retires.
  bdf1_ram #(
    .WIDTH ($bits(hist_t)),
    .DEPTH (CHANNELS)
  ) u_hist_ram (
    .clk   (clk),
    .we    (wb_en),
    .waddr (CH_AW'(tag_acc.channel)),
    .wdata (hist_wb),
    .re    (accept),
    .raddr (CH_AW'(channel)),
    .rdata (hist_raw)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_rd.valid <= 1'b0;
    end else if (advance) begin
      tag_rd.valid <= accept;
    end
    if (advance) begin
      tag_rd.channel  <= channel;
      tag_rd.in_range <= in_range_now;
      x_rd            <= sample_in;
    end
  end

  // Unwritten history reads as zero.
  assign hist_rd = hist_valid[CH_AW'(tag_rd.channel)] ? hist_raw : '0;

  bdf1_mac #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_mac (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .tag_in   (tag_rd),
    .x_in     (x_rd),
    .hist_in  (hist_rd),
    .coefs    (coefs),
    .tag_prod (tag_prod),
    .tag_acc  (tag_acc),
    .acc      (acc),
    .hist_acc (hist_acc)
  );

  // Drop the fraction bits (the rounding offset is already in acc), then clamp.
  always_comb begin
    shifted = acc >>> COEF_FRAC_BITS;
    if (shifted > SAT_HI) begin
      y_sat = SAMPLE_W'(SAMPLE_MAX);
      clip  = 1'b1;
    end else if (shifted < SAT_LO) begin
      y_sat = SAMPLE_W'(SAMPLE_MIN);
      clip  = 1'b1;
    end else begin
      y_sat = shifted[SAMPLE_W-1:0];
      clip  = 1'b0;
    end
    hist_wb    = hist_acc;
    hist_wb.y1 = y_sat;
  end

  assign wb_en = advance && tag_acc.valid && tag_acc.in_range;

  always_ff @(posedge clk) begin
    if (rst) begin
      hist_valid <= '0;
    end else if (wb_en) begin
      hist_valid[CH_AW'(tag_acc.channel)] <= 1'b1;
    end
  end

  // Output register: parts the result side from the pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= tag_acc.valid;
    end
    if (advance) begin
      channel_out <= tag_acc.channel;
      sample_out  <= tag_acc.in_range ? y_sat : '0;
      clipped     <= tag_acc.in_range && clip;
    end
  end

endmodule
`default_nettype wire

// ===== sv/bdf1_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bdf1_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bdf1_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== sv/bdf1_coef_regs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bdf1_coef_regs
// Coefficient register file, written through the plain configuration port.
// ----------------------------------------------------------------------------
module bdf1_coef_regs
  import bdf1_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_write,
  input  wire logic [REG_IDX_W-1:0] cfg_index,
  input  wire logic [COEF_W-1:0]    cfg_data,
  output coef_set_t                 coefs
);

  always_ff @(posedge clk) begin
    if (rst) begin
      coefs.b0 <= B0_RESET;
      coefs.b1 <= '0;
      coefs.b2 <= '0;
      coefs.a1 <= '0;
      coefs.a2 <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_B0:  coefs.b0 <= cfg_data;
        REG_B1:  coefs.b1 <= cfg_data;
        REG_B2:  coefs.b2 <= cfg_data;
        REG_A1:  coefs.a1 <= cfg_data;
        REG_A2:  coefs.a2 <= cfg_data;
        default: ; // drop writes beyond the register list
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== sv/bdf1_mac.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bdf1_mac
// Two-stage multiply-accumulate: five products, then the rounded sum.
// ----------------------------------------------------------------------------
module bdf1_mac
  import bdf1_pkg::*;
#(
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       advance,
  input  tag_t                            tag_in,
  input  wire logic signed [SAMPLE_W-1:0] x_in,
  input  hist_t                           hist_in,
  input  coef_set_t                       coefs,
  output tag_t                            tag_prod,
  output tag_t                            tag_acc,
  output logic signed [ACC_W-1:0]         acc,
  output hist_t                           hist_acc
);

  localparam logic signed [ACC_W-1:0] RND = ACC_W'(1) << (COEF_FRAC_BITS - 1);

  logic signed [PROD_W-1:0] p_b0, p_b1, p_b2, p_a1, p_a2;
  hist_t                    hist_prod;

  // Products stage
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_prod.valid <= 1'b0;
    end else if (advance) begin
      tag_prod.valid <= tag_in.valid;
    end
    if (advance) begin
      tag_prod.channel  <= tag_in.channel;
      tag_prod.in_range <= tag_in.in_range;
      p_b0 <= coefs.b0 * x_in;
      p_b1 <= coefs.b1 * hist_in.x1;
      p_b2 <= coefs.b2 * hist_in.x2;
      p_a1 <= coefs.a1 * hist_in.y1;
      p_a2 <= coefs.a2 * hist_in.y2;
      hist_prod <= '{x1: x_in, x2: hist_in.x1, y1: '0, y2: hist_in.y1};
    end
  end

  // Accumulate stage, rounding offset folded in
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_acc.valid <= 1'b0;
    end else if (advance) begin
      tag_acc.valid <= tag_prod.valid;
    end
    if (advance) begin
      tag_acc.channel  <= tag_prod.channel;
      tag_acc.in_range <= tag_prod.in_range;
      acc <= ACC_W'(p_b0) + ACC_W'(p_b1) + ACC_W'(p_b2)
           - ACC_W'(p_a1) - ACC_W'(p_a2) + RND;
      hist_acc <= hist_prod;
    end
  end

endmodule
`default_nettype wire
